/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted series table.
// Uses the clk_i / rst_ni names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is low.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Condition that must never hold.
`define ASSERT_NEVER(label, cond) \
  `ASSERT_CLK(label, !(cond))

`endif

/* src/sst_pkg.sv */
// Package of the sorted series table: field widths, codes, FSM and command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

  localparam int unsigned YEAR_W = 12;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned OCNT_W = 7;

  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QRY = 2'd2;

  localparam logic [VAL_W-1:0] SENTINEL = 32'hFFFF_0000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD,
    OP_RD_PREV,
    OP_NEXT,
    OP_IDX_CLR,
    OP_SET_SHIFT,
    OP_SHIFT_WR,
    OP_INS_WR,
    OP_UPD_WR,
    OP_ACC1,
    OP_ACC2A,
    OP_ACC2B,
    OP_DEN_A,
    OP_DEN_B,
    OP_DIV_MEAN,
    OP_DIV_SLOPE,
    OP_DIV_ICPT,
    OP_SAVE_MEAN,
    OP_SAVE_SLOPE,
    OP_SAVE_ICPT,
    OP_ICPT_A,
    OP_EMIT
  } sst_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_FULL,
    S_SH_CHK,
    S_SH_WR,
    S_INS,
    S_UPD_RD,
    S_UPD_CHK,
    S_Q1_RD,
    S_Q1_ACC,
    S_Q2_RD,
    S_Q2_A,
    S_Q2_B,
    S_DEN_A,
    S_DEN_B,
    S_MEAN_START,
    S_MEAN_WAIT,
    S_SLOPE_START,
    S_SLOPE_WAIT,
    S_ICPT_A,
    S_ICPT_START,
    S_ICPT_WAIT,
    S_DONE
  } sst_state_e;

  typedef struct packed {
    sst_op_e op;
    logic    ok;
  } sst_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              sentinel;
    logic              full;
    logic              count_zero;
    logic              idx_end;
    logic              idx_eq_pos;
    logic              yr_eq;
    logic              yr_gt;
    logic              den_zero;
    logic              div_done;
    logic              out_free;
  } sst_st_t;

endpackage
`default_nettype wire

/* src/sst_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sst_div #(
  parameter int unsigned W = 61
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic signed [W-1:0] dividend_i,
  input  wire logic signed [W-1:0] divisor_i,
  output logic                     done_o,
  output logic signed [W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     acc_q;
  logic [W:0]       rem_q;
  logic [W-1:0]     dvs_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [W:0]       rem_sh;
  logic [W+1:0]     trial;
  logic             ge;
  logic [W-1:0]     a_abs;
  logic [W-1:0]     b_abs;

  assign a_abs  = dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
  assign b_abs  = divisor_i[W-1] ? W'(-divisor_i) : W'(divisor_i);
  assign rem_sh = {rem_q[W-1:0], acc_q[W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !trial[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= a_abs;
      dvs_q <= b_abs;
      rem_q <= '0;
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      rem_q <= ge ? trial[W:0] : rem_sh;
      acc_q <= {acc_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule
`default_nettype wire

/* src/sst_ctrl.sv */
// Controller FSM of the sorted series table: sequences search, shift, sums and divides.
// Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sst_ctrl import sst_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sst_st_t  st_i,
  output sst_cmd_t      cmd_o
);

  sst_state_e state_q, state_d;
  logic       ok_q, ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ok_d       = ok_q;
    cmd_o.op   = OP_NONE;
    cmd_o.ok   = ok_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          ok_d     = 1'b0;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st_i.kind)
          KIND_ADD: state_d = st_i.sentinel ? S_DONE : S_ADD_RD;
          KIND_UPD: state_d = st_i.sentinel ? S_DONE : S_UPD_RD;
          KIND_QRY: state_d = st_i.count_zero ? S_DONE : S_Q1_RD;
          default:  state_d = S_DONE;
        endcase
      end
      S_ADD_RD: begin
        if (st_i.idx_end) begin
          state_d = S_ADD_FULL;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        if (st_i.yr_eq) begin
          state_d = S_DONE;
        end else if (st_i.yr_gt) begin
          state_d = S_ADD_FULL;
        end else begin
          cmd_o.op = OP_NEXT;
          state_d  = S_ADD_RD;
        end
      end
      S_ADD_FULL: begin
        if (st_i.full) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_SET_SHIFT;
          state_d  = S_SH_CHK;
        end
      end
      S_SH_CHK: begin
        if (st_i.idx_eq_pos) begin
          state_d = S_INS;
        end else begin
          cmd_o.op = OP_RD_PREV;
          state_d  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.op = OP_SHIFT_WR;
        state_d  = S_SH_CHK;
      end
      S_INS: begin
        cmd_o.op = OP_INS_WR;
        ok_d     = 1'b1;
        state_d  = S_DONE;
      end
      S_UPD_RD: begin
        if (st_i.idx_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_UPD_CHK;
        end
      end
      S_UPD_CHK: begin
        if (st_i.yr_eq) begin
          cmd_o.op = OP_UPD_WR;
          ok_d     = 1'b1;
          state_d  = S_DONE;
        end else if (st_i.yr_gt) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_NEXT;
          state_d  = S_UPD_RD;
        end
      end
      S_Q1_RD: begin
        if (st_i.idx_end) begin
          cmd_o.op = OP_IDX_CLR;
          state_d  = S_Q2_RD;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_Q1_ACC;
        end
      end
      S_Q1_ACC: begin
        cmd_o.op = OP_ACC1;
        state_d  = S_Q1_RD;
      end
      S_Q2_RD: begin
        if (st_i.idx_end) begin
          state_d = S_DEN_A;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_Q2_A;
        end
      end
      S_Q2_A: begin
        cmd_o.op = OP_ACC2A;
        state_d  = S_Q2_B;
      end
      S_Q2_B: begin
        cmd_o.op = OP_ACC2B;
        state_d  = S_Q2_RD;
      end
      S_DEN_A: begin
        cmd_o.op = OP_DEN_A;
        state_d  = S_DEN_B;
      end
      S_DEN_B: begin
        cmd_o.op = OP_DEN_B;
        state_d  = S_MEAN_START;
      end
      S_MEAN_START: begin
        cmd_o.op = OP_DIV_MEAN;
        state_d  = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.op = OP_SAVE_MEAN;
          ok_d     = 1'b1;
          state_d  = st_i.den_zero ? S_DONE : S_SLOPE_START;
        end
      end
      S_SLOPE_START: begin
        cmd_o.op = OP_DIV_SLOPE;
        state_d  = S_SLOPE_WAIT;
      end
      S_SLOPE_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.op = OP_SAVE_SLOPE;
          state_d  = S_ICPT_A;
        end
      end
      S_ICPT_A: begin
        cmd_o.op = OP_ICPT_A;
        state_d  = S_ICPT_START;
      end
      S_ICPT_START: begin
        cmd_o.op = OP_DIV_ICPT;
        state_d  = S_ICPT_WAIT;
      end
      S_ICPT_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.op = OP_SAVE_ICPT;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* src/sst_dp.sv */
// Datapath of the sorted series table: point memories, sums, fit products, result register.
// Depends on sst_pkg and sst_div.
`timescale 1ns / 1ps
`default_nettype none
module sst_dp import sst_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sst_cmd_t                 cmd_i,
  output sst_st_t                       st_o,
  input  wire logic [KIND_W-1:0]        in_kind_i,
  input  wire logic [YEAR_W-1:0]        in_year_i,
  input  wire logic signed [VAL_W-1:0]  in_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          out_ok_o,
  output logic [OCNT_W-1:0]             out_count_o,
  output logic signed [VAL_W-1:0]       out_mean_o,
  output logic                          out_mono_o,
  output logic                          out_fit_o,
  output logic signed [VAL_W-1:0]       out_slope_o,
  output logic signed [VAL_W-1:0]       out_icpt_o
);

  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned SX_W  = YEAR_W + CW;
  localparam int unsigned SX2_W = 2 * YEAR_W + CW;
  localparam int unsigned SY_W  = VAL_W + CW;
  localparam int unsigned DW    = CW + YEAR_W + 1;
  localparam int unsigned NUM_W = DW + VAL_W + CW;
  localparam int unsigned W     = NUM_W + 2;
  localparam logic signed [W-1:0] SMAX = W'(32'sh7FFF_FFFF);
  localparam logic signed [W-1:0] SMIN = W'(32'sh8000_0000);

  logic [YEAR_W-1:0] year_mem [MAX_POINTS];
  logic [VAL_W-1:0]  val_mem  [MAX_POINTS];

  logic [KIND_W-1:0]       kind_q;
  logic [YEAR_W-1:0]       year_q;
  logic signed [VAL_W-1:0] value_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           idx_q;
  logic [CW-1:0]           pos_q;
  logic [YEAR_W-1:0]       rd_year_q;
  logic signed [VAL_W-1:0] rd_val_q;
  logic [SX_W-1:0]         sx_q;
  logic signed [SY_W-1:0]  sy_q;
  logic [SX2_W-1:0]        sx2_q;
  logic signed [VAL_W-1:0] prev_q;
  logic                    inc_q, dec_q;
  logic signed [DW-1:0]    d_q;
  logic signed [VAL_W-1:0] v_q;
  logic signed [NUM_W-1:0] num_q;
  logic signed [W-1:0]     p1_q, p2_q, den_q, t_q;
  logic                    fit_q;
  logic signed [VAL_W-1:0] mean_q, slope_q, icpt_q;

  logic                    ovalid_q;
  logic                    ook_q, omono_q, ofit_q;
  logic [OCNT_W-1:0]       ocount_q;
  logic signed [VAL_W-1:0] omean_q, oslope_q, oicpt_q;

  logic                      re, we;
  logic [CW-1:0]             idx_m1;
  logic [AW-1:0]             ra, wa;
  logic [YEAR_W-1:0]         wyear;
  logic [VAL_W-1:0]          wval;
  logic [2*YEAR_W-1:0]       yy;
  logic [CW+YEAR_W-1:0]      ny;
  logic signed [DW+VAL_W-1:0] dv;
  logic [CW+SX2_W-1:0]       nsx2;
  logic [2*SX_W-1:0]         sxsx;
  logic signed [W-1:0]       den_c;
  logic signed [VAL_W+SX_W:0] ps;
  logic                      div_start, div_done;
  logic signed [W-1:0]       div_a, div_b, quot;
  logic signed [VAL_W-1:0]   qsat;

  assign idx_m1 = idx_q - 1'b1;
  assign re     = (cmd_i.op == OP_RD) || (cmd_i.op == OP_RD_PREV);
  assign ra     = (cmd_i.op == OP_RD_PREV) ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign wa     = idx_q[AW-1:0];
  assign we     = (cmd_i.op == OP_SHIFT_WR) || (cmd_i.op == OP_INS_WR) ||
                  (cmd_i.op == OP_UPD_WR);
  assign wyear  = (cmd_i.op == OP_SHIFT_WR) ? rd_year_q : year_q;
  assign wval   = (cmd_i.op == OP_SHIFT_WR) ? rd_val_q : value_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      year_mem[wa] <= wyear;
      val_mem[wa]  <= wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_year_q <= year_mem[ra];
      rd_val_q  <= val_mem[ra];
    end
  end

  assign yy    = rd_year_q * rd_year_q;
  assign ny    = count_q * rd_year_q;
  assign dv    = d_q * v_q;
  assign nsx2  = count_q * sx2_q;
  assign sxsx  = sx_q * sx_q;
  assign den_c = p1_q - p2_q;
  assign ps    = slope_q * $signed({1'b0, sx_q});

  always_comb begin
    div_a = t_q;
    div_b = W'({1'b0, count_q});
    case (cmd_i.op)
      OP_DIV_MEAN:  div_a = W'(sy_q);
      OP_DIV_SLOPE: begin
        div_a = W'(num_q);
        div_b = den_q;
      end
      default: div_a = t_q;
    endcase
  end

  assign div_start = (cmd_i.op == OP_DIV_MEAN) || (cmd_i.op == OP_DIV_SLOPE) ||
                     (cmd_i.op == OP_DIV_ICPT);

  sst_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    if (quot > SMAX) begin
      qsat = 32'sh7FFF_FFFF;
    end else if (quot < SMIN) begin
      qsat = 32'sh8000_0000;
    end else begin
      qsat = quot[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_LOAD, OP_IDX_CLR:   idx_q <= '0;
        OP_NEXT, OP_ACC1, OP_ACC2B: idx_q <= idx_q + 1'b1;
        OP_SET_SHIFT: begin
          pos_q <= idx_q;
          idx_q <= count_q;
        end
        OP_SHIFT_WR: idx_q <= idx_m1;
        OP_INS_WR:   count_q <= count_q + 1'b1;
        default: ;
      endcase
      if (cmd_i.op == OP_EMIT) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        kind_q  <= in_kind_i;
        year_q  <= in_year_i;
        value_q <= in_value_i;
        sx_q    <= '0;
        sy_q    <= '0;
        sx2_q   <= '0;
        num_q   <= '0;
        inc_q   <= 1'b1;
        dec_q   <= 1'b1;
        fit_q   <= 1'b0;
        mean_q  <= '0;
        slope_q <= '0;
        icpt_q  <= '0;
      end
      OP_ACC1: begin
        sx_q   <= sx_q + SX_W'(rd_year_q);
        sy_q   <= sy_q + SY_W'(rd_val_q);
        sx2_q  <= sx2_q + SX2_W'(yy);
        prev_q <= rd_val_q;
        if (idx_q != '0) begin
          if (rd_val_q < prev_q) inc_q <= 1'b0;
          if (rd_val_q > prev_q) dec_q <= 1'b0;
        end
      end
      OP_ACC2A: begin
        d_q <= $signed({1'b0, ny}) - $signed({1'b0, sx_q});
        v_q <= rd_val_q;
      end
      OP_ACC2B:      num_q   <= num_q + NUM_W'(dv);
      OP_DEN_A: begin
        p1_q <= W'(nsx2);
        p2_q <= W'(sxsx);
      end
      OP_DEN_B: begin
        den_q <= den_c;
        fit_q <= (den_c != '0);
      end
      OP_ICPT_A:     t_q     <= W'(sy_q) - W'(ps);
      OP_SAVE_MEAN:  mean_q  <= qsat;
      OP_SAVE_SLOPE: slope_q <= qsat;
      OP_SAVE_ICPT:  icpt_q  <= qsat;
      OP_EMIT: begin
        ook_q    <= cmd_i.ok;
        ocount_q <= OCNT_W'(count_q);
        omean_q  <= mean_q;
        omono_q  <= cmd_i.ok && (kind_q == KIND_QRY) && (inc_q || dec_q);
        ofit_q   <= fit_q;
        oslope_q <= slope_q;
        oicpt_q  <= icpt_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_o.kind       = kind_q;
    st_o.sentinel   = (value_q == SENTINEL);
    st_o.full       = (count_q == CW'(MAX_POINTS));
    st_o.count_zero = (count_q == '0);
    st_o.idx_end    = (idx_q == count_q);
    st_o.idx_eq_pos = (idx_q == pos_q);
    st_o.yr_eq      = (rd_year_q == year_q);
    st_o.yr_gt      = (rd_year_q > year_q);
    st_o.den_zero   = !fit_q;
    st_o.div_done   = div_done;
    st_o.out_free   = !ovalid_q || out_ready_i;
  end

  assign out_valid_o = ovalid_q;
  assign out_ok_o    = ook_q;
  assign out_count_o = ocount_q;
  assign out_mean_o  = omean_q;
  assign out_mono_o  = omono_q;
  assign out_fit_o   = ofit_q;
  assign out_slope_o = oslope_q;
  assign out_icpt_o  = oicpt_q;

endmodule
`default_nettype wire

/* src/sorted_series_table_stats.sv */
// Top level of the sorted series table with mean, monotonicity and least-squares fit.
// Depends on sst_pkg, sst_ctrl, sst_dp (with sst_div) and assert_macros.svh.
//
// channel  dir  tdata                      tuser
// s_axis   in   year, value (48 bits)      kind
// m_axis   out  ok .. intercept (112 bits) -
//
// One request at a time; the result register lets the next request in while it waits.
// Add: searches the entries for the year, then shifts the later entries up to insert.
// Update: searches the entries for the year and rewrites its value.
// Query: two passes over the entries with the one-entry-a-cycle memory read, then the
// mean, slope and intercept divides on the bit-serial divider, W = 2*clog2(MAX_POINTS+1) + 47.
// Reset clears the count, indices and output valid; the point memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sorted_series_table_stats import sst_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [11:0] year, [43:12] value, [47:44] zero
  input  wire logic [47:0]  s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [0] ok, [7:1] point_count, [39:8] mean_value, [40] is_monotone,
  // [41] fit_valid, [73:42] slope, [105:74] intercept, [111:106] zero
  output logic [111:0]      m_axis_tdata_o
);

  sst_cmd_t                cmd;
  sst_st_t                 st;
  logic                    ok, mono, fit;
  logic [OCNT_W-1:0]       cnt;
  logic signed [VAL_W-1:0] mean, slope, icpt;

  sst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  sst_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_kind_i   (s_axis_tuser_i),
    .in_year_i   (s_axis_tdata_i[11:0]),
    .in_value_i  (s_axis_tdata_i[43:12]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_ok_o    (ok),
    .out_count_o (cnt),
    .out_mean_o  (mean),
    .out_mono_o  (mono),
    .out_fit_o   (fit),
    .out_slope_o (slope),
    .out_icpt_o  (icpt)
  );

  assign m_axis_tdata_o = {6'd0, icpt, slope, fit, mono, mean, cnt, ok};

  `ASSERT_CLK(a_one_at_a_time, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
  `ASSERT_NEVER(a_fit_needs_ok, m_axis_tvalid_o && fit && !ok)
  `ASSERT_NEVER(a_mono_needs_ok, m_axis_tvalid_o && mono && !ok)

endmodule
`default_nettype wire
